@@ rtl/c16f_pkg.sv @@
// Shared types, codes and the CRC-16 byte update for the packet framer and checker.
package c16f_pkg;

	// item codes carried in the slave-side tuser
	typedef enum logic [2:0] {
		OP_SEND    = 3'd0,
		OP_END     = 3'd1,
		OP_RDATA   = 3'd2,
		OP_RCRC    = 3'd3,
		OP_ACK     = 3'd4,
		OP_TIMEOUT = 3'd5
	} op_t;

	// transaction status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_CRC_ERR = 2'd1;
	localparam logic [1:0] ST_NACK    = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	// result kinds
	localparam logic KIND_LINE   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [7:0]  ACK_BYTE   = 8'hFF;

	// one result word
	typedef struct packed {
		logic       kind;
		logic [7:0] line_byte;
		logic [1:0] status;
		logic       last;
	} res_t;

	// up to two result words made by one item
	typedef struct packed {
		logic [1:0] n;
		res_t       w0;
		res_t       w1;
	} res_pair_t;

	// CRC-16, MSB first, one byte in eight shift steps
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/c16f_engine.sv @@
// Framing and reply check: CRC state and the result words for one registered item.
module c16f_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  c16f_pkg::op_t        op,
	input  logic [7:0]           byte_in,
	input  logic                 first,
	output c16f_pkg::res_pair_t  res
);
	import c16f_pkg::*;

	logic [15:0] crc_q;
	logic [7:0]  rx_high_q;
	logic        phase_q;

	logic [15:0] crc_d;
	logic [7:0]  rx_high_d;
	logic        phase_d;
	logic [15:0] crc_fed;

	// CRC over the incoming byte, cleared first on a start of packet
	assign crc_fed = crc_feed((op == OP_SEND && first) ? 16'h0000 : crc_q, byte_in);

	// item decode: next state and result words
	always_comb begin
		crc_d     = crc_q;
		rx_high_d = rx_high_q;
		phase_d   = phase_q;
		res       = '0;
		unique case (op)
			OP_SEND: begin
				crc_d     = crc_fed;
				if (first) begin
					phase_d = 1'b0;
				end
				res.n     = 2'd1;
				res.w0    = '{kind: KIND_LINE, line_byte: byte_in, status: ST_OK, last: 1'b1};
			end
			OP_END: begin
				phase_d   = 1'b0;
				res.n     = 2'd2;
				res.w0    = '{kind: KIND_LINE, line_byte: crc_q[15:8], status: ST_OK,
					last: 1'b0};
				res.w1    = '{kind: KIND_LINE, line_byte: crc_q[7:0], status: ST_OK,
					last: 1'b1};
			end
			OP_RDATA: begin
				crc_d     = crc_fed;
			end
			OP_RCRC: begin
				if (!phase_q) begin
					rx_high_d = byte_in;
					phase_d   = 1'b1;
				end else begin
					phase_d   = 1'b0;
					res.n     = 2'd1;
					res.w0    = '{kind: KIND_STATUS, line_byte: 8'h00,
						status: ({rx_high_q, byte_in} == crc_q) ? ST_OK : ST_CRC_ERR,
						last: 1'b1};
				end
			end
			OP_ACK: begin
				phase_d   = 1'b0;
				res.n     = 2'd1;
				res.w0    = '{kind: KIND_STATUS, line_byte: 8'h00,
					status: (byte_in == ACK_BYTE) ? ST_OK : ST_NACK, last: 1'b1};
			end
			OP_TIMEOUT: begin
				phase_d   = 1'b0;
				res.n     = 2'd1;
				res.w0    = '{kind: KIND_STATUS, line_byte: 8'h00, status: ST_TIMEOUT,
					last: 1'b1};
			end
			default: begin
				// unused codes leave everything untouched
			end
		endcase
	end

	// state update on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= '0;
			rx_high_q <= '0;
			phase_q   <= 1'b0;
		end else if (advance) begin
			crc_q     <= crc_d;
			rx_high_q <= rx_high_d;
			phase_q   <= phase_d;
		end
	end

endmodule

@@ rtl/c16f_outq.sv @@
// Small result queue: takes up to two words a cycle, gives one word a cycle while the receiver pops it.
module c16f_outq #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  c16f_pkg::res_pair_t  push,
	output logic                 room,
	output logic                 valid,
	input  logic                 pop,
	output c16f_pkg::res_t       head
);
	import c16f_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] wr_1;
	logic [PW-1:0] wr_2;
	logic [PW-1:0] rd_1;
	logic          do_pop;
	logic          past_ok_q;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_1   = inc(wr_q);
	assign wr_2   = inc(wr_1);
	assign rd_1   = inc(rd_q);
	assign do_pop = pop && valid;

	// room for a two-word item, judged on the registered fill
	assign room  = (count_q <= CW'(DEPTH - 2));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_q];

	// storage words
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.w0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_1] <= push.w1;
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q      <= '0;
			rd_q      <= '0;
			count_q   <= '0;
			past_ok_q <= 1'b0;
		end else begin
			past_ok_q <= 1'b1;
			case (push.n)
				2'd1:    wr_q <= wr_1;
				2'd2:    wr_q <= wr_2;
				default: wr_q <= wr_q;
			endcase
			if (do_pop) begin
				rd_q <= rd_1;
			end
			count_q <= count_q + CW'(push.n) - CW'(do_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(CW + 1)'(count_q) + (CW + 1)'(push.n) <= (CW + 1)'(DEPTH))
		else $error("result queue overflow");

	a_fill_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		past_ok_q |-> count_q == $past(count_q) + CW'($past(push.n)) - CW'($past(do_pop)))
		else $error("result queue fill out of step");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> (push.w1.last && !push.w0.last))
		else $error("two-word item with misplaced last");

endmodule

@@ rtl/crc16_packet_framer_checker_top.sv @@
// Top level of the CRC-16 packet framer and reply checker.
//
// Slave channel s_*: one word per item. tuser carries the item code and the
// start-of-packet flag, tdata the byte sent or received.
// Master channel m_*: result words. tuser marks a line byte (0) or a status
// (1), tdata carries the line byte and the status code, tlast marks the
// final word of an item.
// A send byte gives one line word, an end item gives the CRC as two line
// words high byte first, a second reply CRC byte, an ack byte or a timeout
// gives one status word; reply data and a first reply CRC byte give none.
// Order: an accepted word is held in the input register and processed there
// once the result queue has room; its result words are written into the queue
// and from there presented on m_* to the receiver.
// Throughput: one item per cycle while the result queue has room for two
// words; an end item gives two words to the master side, so the queue
// depth sets how long the slave side keeps flowing when results back up.
// Reset clears the CRC, the stored high byte and the byte phase and empties
// the queue. When the receiver stalls the queue fills and s_tready drops.
module crc16_packet_framer_checker_top #(
	parameter int OUTQ_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic [3:0]  s_tuser,   // [2:0] op, [3] first
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] line_byte, [9:8] status, [15:10] zero
	output logic [0:0]  m_tuser,   // [0] kind
	output logic        m_tlast
);
	import c16f_pkg::*;

	logic        valid_s1;
	op_t         op_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        advance;
	logic        room;
	res_pair_t   eng_res;
	res_pair_t   push;
	res_t        head;

	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= op_t'(s_tuser[2:0]);
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser[3];
		end
	end

	c16f_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.op      (op_s1),
		.byte_in (byte_s1),
		.first   (first_s1),
		.res     (eng_res)
	);

	// only an item that moves on pushes words
	always_comb begin
		push = eng_res;
		if (!advance) begin
			push.n = 2'd0;
		end
	end

	c16f_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.valid  (m_tvalid),
		.pop    (m_tready),
		.head   (head)
	);

	// master-side packing
	assign m_tdata = {6'b000000, head.status, head.line_byte};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

@@ bench/crc16_packet_framer_checker_top_tb.sv @@
// Self-checking testbench for the CRC-16 packet framer and reply checker.
module crc16_packet_framer_checker_top_tb;
	import c16f_pkg::*;

	localparam int        LIMIT_CYCLES = 400000;
	localparam int        RANDOM_ITEMS = 1950;
	localparam int        MAX_REPORTS  = 10;
	localparam logic [2:0] OP_SPARE_6  = 3'd6;
	localparam logic [2:0] OP_SPARE_7  = 3'd7;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;  // [7:0] byte_in
	logic [3:0]  s_tuser  = 4'h0;   // [2:0] op, [3] first
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // [7:0] line_byte, [9:8] status, [15:10] zero
	logic [0:0]  m_tuser;           // [0] kind
	logic        m_tlast;

	// predictor state
	logic [15:0] link_crc    = 16'h0000;
	logic [7:0]  rx_crc_high = 8'h00;
	logic        rx_low_next = 1'b0;
	res_t        expected_words[$];

	int errors     = 0;
	int items_sent = 0;
	int burst_left = 0;
	int cycles     = 0;
	int rx_left    = 0;
	logic rx_ready_phase = 1'b0;

	crc16_packet_framer_checker_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// bitwise CRC-16, polynomial 0x1021, MSB first
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
		end
		return c;
	endfunction

	function automatic res_t link_word(input logic kind, input logic [7:0] lb,
			input logic [1:0] st, input logic lst);
		res_t w;
		w.kind      = kind;
		w.line_byte = lb;
		w.status    = st;
		w.last      = lst;
		return w;
	endfunction

	// expected words for one accepted item
	task automatic predict_link_words(input logic [2:0] op, input logic [7:0] b,
			input logic f);
		case (op)
			OP_SEND: begin
				if (f) begin
					link_crc    = 16'h0000;
					rx_low_next = 1'b0;
				end
				link_crc = crc16_step(link_crc, b);
				expected_words.push_back(link_word(KIND_LINE, b, ST_OK, 1'b1));
			end
			OP_END: begin
				rx_low_next = 1'b0;
				expected_words.push_back(link_word(KIND_LINE, link_crc[15:8], ST_OK, 1'b0));
				expected_words.push_back(link_word(KIND_LINE, link_crc[7:0], ST_OK, 1'b1));
			end
			OP_RDATA: begin
				link_crc = crc16_step(link_crc, b);
			end
			OP_RCRC: begin
				if (!rx_low_next) begin
					rx_crc_high = b;
					rx_low_next = 1'b1;
				end else begin
					rx_low_next = 1'b0;
					expected_words.push_back(link_word(KIND_STATUS, 8'h00,
						({rx_crc_high, b} == link_crc) ? ST_OK : ST_CRC_ERR, 1'b1));
				end
			end
			OP_ACK: begin
				rx_low_next = 1'b0;
				expected_words.push_back(link_word(KIND_STATUS, 8'h00,
					(b == ACK_BYTE) ? ST_OK : ST_NACK, 1'b1));
			end
			OP_TIMEOUT: begin
				rx_low_next = 1'b0;
				expected_words.push_back(link_word(KIND_STATUS, 8'h00, ST_TIMEOUT, 1'b1));
			end
			default: ;
		endcase
	endtask

	// send one word, in bursts with random gaps between them
	task automatic send_word(input logic [2:0] op, input logic [7:0] b, input logic f);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= {f, op};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (op <= OP_TIMEOUT)
			items_sent++;
		predict_link_words(op, b, f);
	endtask

	// receiver stall pattern: ready runs and stall runs of random length
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_ready_phase = !rx_ready_phase;
			if (rx_ready_phase)
				rx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
					: $urandom_range(1, 24);
			else
				rx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
					: $urandom_range(1, 4);
		end
		rx_left--;
		m_tready <= rx_ready_phase;
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		res_t        w;
		logic [15:0] exp_tdata;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("unexpected word: kind=%0d tdata=%h last=%0d",
						m_tuser[0], m_tdata, m_tlast);
				errors++;
			end else begin
				w = expected_words.pop_front();
				exp_tdata = {6'b0, w.status, w.line_byte};
				if (m_tuser[0] !== w.kind || m_tdata !== exp_tdata
						|| m_tlast !== w.last) begin
					if (errors < MAX_REPORTS)
						$display("mismatch: expected kind=%0d tdata=%h last=%0d",
							w.kind, exp_tdata, w.last,
							", got kind=%0d tdata=%h last=%0d",
							m_tuser[0], m_tdata, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// extremes, every op and the corner cases of the crc byte phase
	task automatic test_directed;
		send_word(OP_SEND, 8'hA5, 1'b0);       // crc straight from reset
		send_word(OP_END, 8'h00, 1'b0);
		send_word(OP_SEND, 8'h80, 1'b1);
		send_word(OP_SEND, 8'h00, 1'b0);
		send_word(OP_SEND, 8'hFF, 1'b0);
		send_word(OP_END, 8'hFF, 1'b1);        // stray first on end
		send_word(OP_ACK, 8'hFF, 1'b0);
		send_word(OP_ACK, 8'h00, 1'b0);
		send_word(OP_ACK, 8'hFE, 1'b1);
		send_word(OP_RDATA, 8'h12, 1'b1);      // stray first on reply data
		send_word(OP_RDATA, 8'hFF, 1'b0);
		send_word(OP_RCRC, link_crc[15:8], 1'b0);
		send_word(OP_RCRC, link_crc[7:0], 1'b0);
		send_word(OP_RCRC, link_crc[15:8], 1'b0);
		send_word(OP_RCRC, ~link_crc[7:0], 1'b1);
		send_word(OP_TIMEOUT, 8'hFF, 1'b1);
		send_word(OP_SPARE_6, 8'h55, 1'b1);   // unused codes do nothing
		send_word(OP_SPARE_7, 8'hAA, 1'b0);
		send_word(OP_RCRC, 8'h3C, 1'b0);
		send_word(OP_TIMEOUT, 8'h00, 1'b0);    // timeout drops the half-received crc
		send_word(OP_RCRC, 8'hC3, 1'b0);
		send_word(OP_SEND, 8'h5A, 1'b1);       // start of packet drops it too
		send_word(OP_RCRC, link_crc[15:8], 1'b0);
		send_word(OP_RCRC, link_crc[7:0], 1'b0);
	endtask

	// mostly well-formed command/reply exchanges, some noise
	task automatic test_random_transactions;
		int          target;
		int          n;
		int          sel;
		logic [3:0]  bitpos;
		logic [15:0] rx_crc;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			if ($urandom_range(0, 9) < 8) begin
				send_word(OP_SEND, 8'($urandom_range(0, 255)), 1'b1);
				n = $urandom_range(0, 6);
				repeat (n) send_word(OP_SEND, 8'($urandom_range(0, 255)), 1'b0);
				send_word(OP_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				sel = $urandom_range(0, 5);
				if (sel < 2) begin
					send_word(OP_ACK, ($urandom_range(0, 3) != 0) ? ACK_BYTE
						: 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end else if (sel < 5) begin
					n = $urandom_range(0, 6);
					repeat (n) send_word(OP_RDATA, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
					rx_crc = link_crc;
					if ($urandom_range(0, 3) == 0) begin
						bitpos = 4'($urandom_range(0, 15));
						rx_crc[bitpos] = ~rx_crc[bitpos];
					end
					send_word(OP_RCRC, rx_crc[15:8], 1'($urandom_range(0, 1)));
					send_word(OP_RCRC, rx_crc[7:0], 1'($urandom_range(0, 1)));
				end else begin
					send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				end
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) send_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_transactions();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
